@@ src/j2gv_pkg.sv @@
package j2gv_pkg;

    localparam int AW = 6;
    localparam int DW = 64;

    localparam int MW = 48;
    localparam int MH = MW / 2;
    localparam int PW = 2 * MW;

    localparam int SQ_IW = 82;
    localparam int SQ_OW = 41;

    localparam int DN_W = 97;
    localparam int DD_W = 82;
    localparam int DQ_W = 48;

    localparam int L_MUL = 2;
    localparam int L_SQRT = SQ_OW;
    localparam int L_DIV = DQ_W;

    localparam int C_MAG = 1;
    localparam int C_SUM = C_MAG + L_MUL + 1;
    localparam int C_RAD = C_SUM + L_SQRT;
    localparam int C_DEN = C_RAD + L_MUL;
    localparam int C_UM = C_RAD + L_DIV;
    localparam int C_DOT = C_UM + L_MUL;
    localparam int C_QG = C_DEN + L_DIV;
    localparam int C_S = C_QG + 1;
    localparam int C_T = C_S + L_MUL + 1;
    localparam int C_F = C_T + L_MUL + 1;
    localparam int C_GR = C_F + L_MUL + 1;
    localparam int C_ACC = C_GR + L_MUL;
    localparam int LAT = C_ACC + 1;

    localparam logic [30:0] ONE30 = 31'h4000_0000;
    localparam logic [33:0] ONE32 = 34'h1_0000_0000;
    localparam logic [47:0] G_CAP = 48'h8000_0000_0000;
    localparam logic [39:0] RAD_MAX = 40'hFF_FFFF_FFFF;
    localparam logic signed [50:0] A_MAX = 51'sd549755813887;
    localparam logic signed [50:0] A_MIN = -51'sd549755813888;

    typedef enum logic [2:0] {
        REG_SITE_X,
        REG_SITE_Y,
        REG_SITE_Z,
        REG_SPIN_X,
        REG_SPIN_Y,
        REG_SPIN_Z,
        REG_GRAV_PARAM,
        REG_OBLATE_COEFF
    } reg_idx_t;

    typedef struct packed {
        logic signed [39:0] pos_x;
        logic signed [39:0] pos_y;
        logic signed [39:0] pos_z;
    } item_t;

    typedef struct packed {
        logic signed [39:0] accel_x;
        logic signed [39:0] accel_y;
        logic signed [39:0] accel_z;
        logic [39:0]        radius;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic [DQ_W-1:0] quo;
        logic            ovf;
    } div_out_t;

endpackage

@@ src/j2gv_mul.sv @@
module j2gv_mul (
    input  logic                     clk,
    input  logic [j2gv_pkg::MW-1:0]  a,
    input  logic [j2gv_pkg::MW-1:0]  b,
    output logic [j2gv_pkg::PW-1:0]  p
);
    import j2gv_pkg::*;

    logic [MW-1:0] pp_reg [4];
    logic [PW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        pp_reg[0] <= MW'(a[MH-1:0]) * MW'(b[MH-1:0]);
        pp_reg[1] <= MW'(a[MH-1:0]) * MW'(b[MW-1:MH]);
        pp_reg[2] <= MW'(a[MW-1:MH]) * MW'(b[MH-1:0]);
        pp_reg[3] <= MW'(a[MW-1:MH]) * MW'(b[MW-1:MH]);
        p_reg <= PW'(pp_reg[0]) + (PW'(pp_reg[1]) << MH) + (PW'(pp_reg[2]) << MH)
               + (PW'(pp_reg[3]) << MW);
    end

    assign p = p_reg;

endmodule

@@ src/j2gv_sqrt.sv @@
module j2gv_sqrt (
    input  logic                       clk,
    input  logic [j2gv_pkg::SQ_IW-1:0] sum,
    output logic [j2gv_pkg::SQ_OW-1:0] root
);
    import j2gv_pkg::*;

    logic [SQ_IW-1:0] rem_reg [SQ_OW];
    logic [SQ_OW-1:0] res_reg [SQ_OW];

    for (genvar k = 0; k < SQ_OW; k++)
    begin : g_stage
        localparam int B = SQ_OW - 1 - k;
        logic [SQ_IW-1:0] rem_in;
        logic [SQ_OW-1:0] res_in;
        logic [SQ_IW+1:0] rem_ext;
        logic [SQ_IW+1:0] trial;
        logic             take;

        if (k == 0)
        begin : g_first
            assign rem_in = sum;
            assign res_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign rem_ext = (SQ_IW+2)'(rem_in);
        assign trial = ((SQ_IW+2)'(res_in) << (B + 1)) | ((SQ_IW+2)'(1) << (2 * B));
        assign take = rem_ext >= trial;

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= take ? SQ_IW'(rem_ext - trial) : rem_in;
            res_reg[k] <= take ? (res_in | (SQ_OW'(1) << B)) : res_in;
        end
    end

    assign root = res_reg[SQ_OW-1];

endmodule

@@ src/j2gv_div.sv @@
module j2gv_div (
    input  logic                      clk,
    input  logic [j2gv_pkg::DN_W-1:0] num,
    input  logic [j2gv_pkg::DD_W-1:0] den,
    output j2gv_pkg::div_out_t        res
);
    import j2gv_pkg::*;

    logic [DD_W-1:0] p_reg   [DQ_W];
    logic [DQ_W-1:0] low_reg [DQ_W];
    logic [DQ_W-1:0] q_reg   [DQ_W];
    logic [DD_W-1:0] d_reg   [DQ_W];
    logic            ovf_reg [DQ_W];

    for (genvar k = 0; k < DQ_W; k++)
    begin : g_stage
        logic [DD_W-1:0] p_in;
        logic [DQ_W-1:0] low_in;
        logic [DQ_W-1:0] q_in;
        logic [DD_W-1:0] d_in;
        logic            ovf_in;
        logic [DD_W:0]   pe;
        logic            take;

        if (k == 0)
        begin : g_first
            assign p_in = DD_W'(num[DN_W-1:DQ_W]);
            assign low_in = num[DQ_W-1:0];
            assign q_in = '0;
            assign d_in = den;
            assign ovf_in = DD_W'(num[DN_W-1:DQ_W]) >= den;
        end
        else
        begin : g_next
            assign p_in = p_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in = q_reg[k-1];
            assign d_in = d_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
        end

        assign pe = {p_in, low_in[DQ_W-1]};
        assign take = pe >= {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            p_reg[k] <= take ? DD_W'(pe - {1'b0, d_in}) : DD_W'(pe);
            low_reg[k] <= {low_in[DQ_W-2:0], 1'b0};
            q_reg[k] <= {q_in[DQ_W-2:0], take};
            d_reg[k] <= d_in;
            ovf_reg[k] <= ovf_in;
        end
    end

    assign res.quo = q_reg[DQ_W-1];
    assign res.ovf = ovf_reg[DQ_W-1];

endmodule

@@ src/j2_gravity_vector.sv @@
// J2 gravity vector unit.
// An item is a vehicle position (pos_x, pos_y, pos_z) in the launch frame. It is
// taken at a rising edge with start high and busy low; busy is never raised, so a
// new transaction may be presented in every cycle.
// Each item gives one result (three acceleration components, the radius and a
// saturation flag), shown on result for exactly one cycle with done high.
// Results leave in the order items arrived. The pipeline runs through the
// squaring of the position, the 41-stage square root, the squaring of the radius
// and the 48-stage dividers for C/r^2 and GM/r^2 behind it, then the chain of
// two-stage multipliers that follows. The dividers for the unit vector run
// alongside and add nothing to its length.
// Throughput is one item per clock cycle.
// The receiver cannot hold results off, so nothing in the pipeline ever stalls.
// Configuration registers sit on the APB port at byte address 8*index and take
// effect for items accepted after the write; they should be written only while
// no transaction is in flight. Reset empties the pipeline and loads the default
// site, spin axis, gravitational parameter and oblateness coefficient.
module j2_gravity_vector (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  j2gv_pkg::item_t         item,
    output logic                    done,
    output j2gv_pkg::result_t       result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [j2gv_pkg::AW-1:0] paddr,
    input  logic [j2gv_pkg::DW-1:0] pwdata,
    output logic [j2gv_pkg::DW-1:0] prdata,
    output logic                    pready
);
    import j2gv_pkg::*;

    logic [39:0] site_x_reg, site_y_reg, site_z_reg;
    logic [31:0] spin_x_reg, spin_y_reg, spin_z_reg;
    logic [48:0] grav_param_reg;
    logic [39:0] oblate_coeff_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready = 1'b1;
    assign busy = 1'b0;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[AW-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_x_reg <= '0;
            site_y_reg <= '0;
            site_z_reg <= '0;
            spin_x_reg <= '0;
            spin_y_reg <= 32'h4000_0000;
            spin_z_reg <= '0;
            grav_param_reg <= 49'd398600441800000;
            oblate_coeff_reg <= 40'd66063000000;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SITE_X:       site_x_reg <= pwdata[39:0];
                REG_SITE_Y:       site_y_reg <= pwdata[39:0];
                REG_SITE_Z:       site_z_reg <= pwdata[39:0];
                REG_SPIN_X:       spin_x_reg <= pwdata[31:0];
                REG_SPIN_Y:       spin_y_reg <= pwdata[31:0];
                REG_SPIN_Z:       spin_z_reg <= pwdata[31:0];
                REG_GRAV_PARAM:   grav_param_reg <= pwdata[48:0];
                REG_OBLATE_COEFF: oblate_coeff_reg <= pwdata[39:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SITE_X:       prdata = DW'(site_x_reg);
            REG_SITE_Y:       prdata = DW'(site_y_reg);
            REG_SITE_Z:       prdata = DW'(site_z_reg);
            REG_SPIN_X:       prdata = DW'(spin_x_reg);
            REG_SPIN_Y:       prdata = DW'(spin_y_reg);
            REG_SPIN_Z:       prdata = DW'(spin_z_reg);
            REG_GRAV_PARAM:   prdata = DW'(grav_param_reg);
            REG_OBLATE_COEFF: prdata = DW'(oblate_coeff_reg);
            default:          prdata = '0;
        endcase
    end

    logic [LAT:1] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-1:1], start & ~busy};
        end
    end

    logic [39:0] site_v [3];
    logic [39:0] pos_v  [3];
    logic [31:0] spin_v [3];
    logic [31:0] wabs   [3];
    logic [40:0] rsum   [3];
    logic [2:0]        neg_next;
    logic [2:0][40:0]  mag_next;

    assign site_v[0] = site_x_reg;
    assign site_v[1] = site_y_reg;
    assign site_v[2] = site_z_reg;
    assign pos_v[0] = item.pos_x;
    assign pos_v[1] = item.pos_y;
    assign pos_v[2] = item.pos_z;
    assign spin_v[0] = spin_x_reg;
    assign spin_v[1] = spin_y_reg;
    assign spin_v[2] = spin_z_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rsum[i] = {site_v[i][39], site_v[i]} + {pos_v[i][39], pos_v[i]};
            neg_next[i] = rsum[i][40];
            mag_next[i] = rsum[i][40] ? ((~rsum[i]) + 41'd1) : rsum[i];
            wabs[i] = spin_v[i][31] ? ((~spin_v[i]) + 32'd1) : spin_v[i];
        end
    end

    logic [2:0][40:0] mag_reg [C_MAG:C_RAD];
    logic [2:0]       neg_reg [C_MAG:C_ACC];

    always_ff @(posedge clk)
    begin
        mag_reg[C_MAG] <= mag_next;
        neg_reg[C_MAG] <= neg_next;
        for (int k = C_MAG + 1; k <= C_RAD; k++)
        begin
            mag_reg[k] <= mag_reg[k-1];
        end
        for (int k = C_MAG + 1; k <= C_ACC; k++)
        begin
            neg_reg[k] <= neg_reg[k-1];
        end
    end

    logic [PW-1:0]    sq_p [3];
    logic [SQ_IW-1:0] sum_reg;
    logic [SQ_OW-1:0] rad;
    logic [PW-1:0]    den_p;
    div_out_t         um_d [3];
    div_out_t         q_d;
    div_out_t         g_d;
    logic [2:0][30:0] um_w;
    logic [PW-1:0]    dp [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_lane_a
        j2gv_mul u_sq (
            .clk (clk),
            .a   (MW'(mag_reg[C_MAG][i])),
            .b   (MW'(mag_reg[C_MAG][i])),
            .p   (sq_p[i])
        );

        j2gv_div u_um (
            .clk (clk),
            .num ((DN_W'(mag_reg[C_RAD][i]) << 30) + DN_W'(rad >> 1)),
            .den (DD_W'(rad)),
            .res (um_d[i])
        );

        assign um_w[i] = um_d[i].quo[30:0];

        j2gv_mul u_dot (
            .clk (clk),
            .a   (MW'(um_w[i])),
            .b   (MW'(wabs[i])),
            .p   (dp[i])
        );
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sq_p[0][SQ_IW-1:0] + sq_p[1][SQ_IW-1:0] + sq_p[2][SQ_IW-1:0];
    end

    j2gv_sqrt u_sqrt (
        .clk  (clk),
        .sum  (sum_reg),
        .root (rad)
    );

    j2gv_mul u_den (
        .clk (clk),
        .a   (MW'(rad)),
        .b   (MW'(rad)),
        .p   (den_p)
    );

    j2gv_div u_q (
        .clk (clk),
        .num (DN_W'({oblate_coeff_reg, 48'd0})),
        .den (den_p[DD_W-1:0]),
        .res (q_d)
    );

    j2gv_div u_g0 (
        .clk (clk),
        .num ({grav_param_reg, 48'd0}),
        .den (den_p[DD_W-1:0]),
        .res (g_d)
    );

    logic [2:0][30:0] um_reg  [C_UM+1:C_GR];
    logic [40:0]      rad_reg [C_RAD+1:C_ACC];

    always_ff @(posedge clk)
    begin
        um_reg[C_UM+1] <= um_w;
        for (int k = C_UM + 2; k <= C_GR; k++)
        begin
            um_reg[k] <= um_reg[k-1];
        end
        rad_reg[C_RAD+1] <= rad;
        for (int k = C_RAD + 2; k <= C_ACC; k++)
        begin
            rad_reg[k] <= rad_reg[k-1];
        end
    end

    logic [64:0] term [3];
    logic [64:0] dot;
    logic [64:0] dabs;
    logic [64:0] dround;
    logic [34:0] sm_raw;
    logic [30:0] sm_next;
    logic        qclip;
    logic        gclip;
    logic [30:0] q_next;
    logic [47:0] g0_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            term[i] = (neg_reg[C_DOT][i] ^ spin_v[i][31]) ? (65'd0 - 65'(dp[i][61:0]))
                                                          : 65'(dp[i][61:0]);
        end
        dot = term[0] + term[1] + term[2];
        dabs = dot[64] ? ((~dot) + 65'd1) : dot;
        dround = dabs + (65'd1 << 29);
        sm_raw = dround[64:30];
        sm_next = (sm_raw > 35'(ONE30)) ? ONE30 : sm_raw[30:0];
        qclip = q_d.ovf | (q_d.quo > 48'(ONE30));
        q_next = qclip ? ONE30 : q_d.quo[30:0];
        gclip = g_d.ovf | (g_d.quo > G_CAP);
        g0_next = gclip ? G_CAP : g_d.quo;
    end

    logic [30:0] sm_reg   [C_S:C_T];
    logic        sneg_reg [C_S:C_ACC];
    logic [30:0] q_reg    [C_S:C_T];
    logic [47:0] g0_reg   [C_S:C_F];
    logic        clip_reg [C_S:C_ACC];

    always_ff @(posedge clk)
    begin
        sm_reg[C_S] <= sm_next;
        q_reg[C_S] <= q_next;
        sneg_reg[C_S] <= dot[64];
        g0_reg[C_S] <= g0_next;
        clip_reg[C_S] <= qclip | gclip;
        for (int k = C_S + 1; k <= C_T; k++)
        begin
            sm_reg[k] <= sm_reg[k-1];
            q_reg[k] <= q_reg[k-1];
        end
        for (int k = C_S + 1; k <= C_F; k++)
        begin
            g0_reg[k] <= g0_reg[k-1];
        end
        for (int k = C_S + 1; k <= C_ACC; k++)
        begin
            sneg_reg[k] <= sneg_reg[k-1];
            clip_reg[k] <= clip_reg[k-1];
        end
    end

    logic [PW-1:0] smsq_p;
    logic [PW-1:0] g0q_p;

    j2gv_mul u_smsq (
        .clk (clk),
        .a   (MW'(sm_reg[C_S])),
        .b   (MW'(sm_reg[C_S])),
        .p   (smsq_p)
    );

    j2gv_mul u_g0q (
        .clk (clk),
        .a   (g0_reg[C_S]),
        .b   (MW'(q_reg[C_S])),
        .p   (g0q_p)
    );

    logic [63:0]   s5;
    logic [63:0]   s5r;
    logic [33:0]   t_next;
    logic [PW-1:0] hs1r;
    logic [46:0]   hs1_next;
    logic [33:0]   t_reg;
    logic [46:0]   hs1_reg;
    logic [33:0]   tabs;

    always_comb
    begin
        s5 = {1'b0, smsq_p[60:0], 2'b00} + 64'(smsq_p[60:0]);
        s5r = s5 + (64'd1 << 29);
        t_next = 34'(ONE30) - s5r[63:30];
        hs1r = g0q_p + (PW'(1) << 30);
        hs1_next = hs1r[77:31];
        tabs = t_reg[33] ? ((~t_reg) + 34'd1) : t_reg;
    end

    logic tneg_reg [C_T+1:C_F-1];

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        hs1_reg <= hs1_next;
        tneg_reg[C_T+1] <= t_reg[33];
        for (int k = C_T + 2; k <= C_F - 1; k++)
        begin
            tneg_reg[k] <= tneg_reg[k-1];
        end
    end

    logic [PW-1:0] qt_p;
    logic [PW-1:0] hsm_p;

    j2gv_mul u_qt (
        .clk (clk),
        .a   (MW'(q_reg[C_T])),
        .b   (MW'(tabs)),
        .p   (qt_p)
    );

    j2gv_mul u_hsm (
        .clk (clk),
        .a   (MW'(hs1_reg)),
        .b   (MW'(sm_reg[C_T])),
        .p   (hsm_p)
    );

    logic [PW-1:0] qtr;
    logic [32:0]   corr;
    logic [33:0]   f_next;
    logic [PW-1:0] hsr;
    logic [46:0]   hs_next;

    always_comb
    begin
        qtr = qt_p + (PW'(1) << 29);
        corr = qtr[62:30];
        f_next = tneg_reg[C_F-1] ? (ONE32 - 34'(corr)) : (ONE32 + 34'(corr));
        hsr = hsm_p + (PW'(1) << 29);
        hs_next = hsr[76:30];
    end

    logic [33:0] f_reg;
    logic [46:0] hs_reg [C_F:C_GR];

    always_ff @(posedge clk)
    begin
        f_reg <= f_next;
        hs_reg[C_F] <= hs_next;
        for (int k = C_F + 1; k <= C_GR; k++)
        begin
            hs_reg[k] <= hs_reg[k-1];
        end
    end

    logic [PW-1:0] gf_p;
    logic [PW-1:0] grr;
    logic [47:0]   gr_reg;

    j2gv_mul u_gf (
        .clk (clk),
        .a   (g0_reg[C_F]),
        .b   (MW'(f_reg)),
        .p   (gf_p)
    );

    assign grr = gf_p + (PW'(1) << 31);

    always_ff @(posedge clk)
    begin
        gr_reg <= grr[79:32];
    end

    logic [PW-1:0] gu_p [3];
    logic [PW-1:0] hw_p [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_lane_b
        j2gv_mul u_gu (
            .clk (clk),
            .a   (gr_reg),
            .b   (MW'(um_reg[C_GR][i])),
            .p   (gu_p[i])
        );

        j2gv_mul u_hw (
            .clk (clk),
            .a   (MW'(hs_reg[C_GR])),
            .b   (MW'(wabs[i])),
            .p   (hw_p[i])
        );
    end

    logic [PW-1:0]      t1r  [3];
    logic [PW-1:0]      t2r  [3];
    logic signed [50:0] st1  [3];
    logic signed [50:0] st2  [3];
    logic signed [50:0] acc  [3];
    logic [39:0]        accq [3];
    logic [2:0]         aclip;
    logic [40:0]        rad_f;
    result_t            result_next;
    result_t            result_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t1r[i] = gu_p[i] + (PW'(1) << 29);
            t2r[i] = hw_p[i] + (PW'(1) << 29);
            st1[i] = neg_reg[C_ACC][i] ? (51'd0 - 51'(t1r[i][77:30])) : 51'(t1r[i][77:30]);
            st2[i] = (sneg_reg[C_ACC] ^ spin_v[i][31]) ? (51'd0 - 51'(t2r[i][77:30]))
                                                       : 51'(t2r[i][77:30]);
            acc[i] = -(st1[i] + st2[i]);
            aclip[i] = 1'b0;
            accq[i] = acc[i][39:0];
            if (acc[i] > A_MAX)
            begin
                aclip[i] = 1'b1;
                accq[i] = A_MAX[39:0];
            end
            else if (acc[i] < A_MIN)
            begin
                aclip[i] = 1'b1;
                accq[i] = A_MIN[39:0];
            end
        end
        rad_f = rad_reg[C_ACC];
        if (rad_f == '0)
        begin
            result_next = '0;
            result_next.saturated = 1'b1;
        end
        else
        begin
            result_next.accel_x = accq[0];
            result_next.accel_y = accq[1];
            result_next.accel_z = accq[2];
            result_next.radius = rad_f[40] ? RAD_MAX : rad_f[39:0];
            result_next.saturated = rad_f[40] | clip_reg[C_ACC] | (|aclip);
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done = vld_reg[LAT];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("A transaction did not complete after the pipeline latency.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("A result appeared without a matching input transaction.");

    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.radius == '0) |->
            (result.saturated && result.accel_x == '0 && result.accel_y == '0
             && result.accel_z == '0))
        else $error("A zero radius result was not flagged and cleared.");

endmodule

@@ test/j2gv_checker.sv @@
module j2gv_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  j2gv_pkg::item_t         item,
    input  logic                    done,
    input  j2gv_pkg::result_t       result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [j2gv_pkg::AW-1:0] paddr,
    input  logic [j2gv_pkg::DW-1:0] pwdata,
    input  logic                    pready,
    output int                      mismatches,
    output int                      outstanding,
    output int                      results_seen
);
    import j2gv_pkg::*;

    logic [39:0] site_q [3];
    logic [31:0] spin_q [3];
    logic [48:0] gm_q;
    logic [39:0] coeff_q;
    result_t     gravity_q [$];

    function automatic logic [63:0] round_shift(logic [127:0] x, int n);
        logic [127:0] y;
        y = (x + (128'd1 << (n - 1))) >> n;
        return y[63:0];
    endfunction

    function automatic result_t gravity_of(item_t it);
        logic signed [41:0] r;
        logic [39:0]        p;
        logic [127:0]       sum, den, quo;
        logic [63:0]        mag [3];
        logic [63:0]        um [3];
        logic [63:0]        rad, c, sm, q, corr, f, g0, gr, hs, t1, t2, wabs;
        logic               neg [3];
        longint             w [3];
        longint             dot, t, qt, a;
        logic               sneg, clip;
        result_t            res;
        sum = '0;
        dot = 0;
        clip = 1'b0;
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            p = (i == 0) ? it.pos_x : (i == 1) ? it.pos_y : it.pos_z;
            r = {{2{site_q[i][39]}}, site_q[i]} + {{2{p[39]}}, p};
            neg[i] = r[41];
            mag[i] = r[41] ? 64'(-r) : 64'(r);
            sum = sum + 128'(mag[i]) * 128'(mag[i]);
            w[i] = longint'($signed(spin_q[i]));
        end
        rad = '0;
        for (int b = 41; b >= 0; b--)
        begin
            c = rad | (64'd1 << b);
            if (128'(c) * 128'(c) <= sum)
                rad = c;
        end
        if (rad == 0)
        begin
            res.saturated = 1'b1;
            return res;
        end
        if (rad > 64'(RAD_MAX))
        begin
            res.radius = RAD_MAX;
            clip = 1'b1;
        end
        else
            res.radius = rad[39:0];
        den = 128'(rad) * 128'(rad);
        for (int i = 0; i < 3; i++)
        begin
            quo = ((128'(mag[i]) << 30) + 128'(rad >> 1)) / 128'(rad);
            um[i] = quo[63:0];
            dot += (neg[i] ? -longint'(um[i]) : longint'(um[i])) * w[i];
        end
        sneg = dot < 0;
        sm = (64'(dot < 0 ? -dot : dot) + 64'd536870912) >> 30;
        if (sm > 64'd1073741824)
            sm = 64'd1073741824;
        t = 64'sd1073741824 - longint'((64'd5 * sm * sm + 64'd536870912) >> 30);
        quo = (128'(coeff_q) << 48) / den;
        if (quo > 128'd1073741824)
        begin
            q = 64'd1073741824;
            clip = 1'b1;
        end
        else
            q = quo[63:0];
        qt = longint'(q) * t;
        corr = (64'(qt < 0 ? -qt : qt) + 64'd536870912) >> 30;
        f = (qt < 0) ? (64'd4294967296 - corr) : (64'd4294967296 + corr);
        quo = (128'(gm_q) << 48) / den;
        if (quo > 128'(G_CAP))
        begin
            g0 = 64'(G_CAP);
            clip = 1'b1;
        end
        else
            g0 = quo[63:0];
        gr = round_shift(128'(g0) * 128'(f), 32);
        hs = round_shift(128'(round_shift(128'(g0) * 128'(q), 31)) * 128'(sm), 30);
        for (int i = 0; i < 3; i++)
        begin
            wabs = 64'(w[i] < 0 ? -w[i] : w[i]);
            t1 = round_shift(128'(gr) * 128'(um[i]), 30);
            t2 = round_shift(128'(hs) * 128'(wabs), 30);
            a = (neg[i] ? -longint'(t1) : longint'(t1))
              + ((sneg != (w[i] < 0)) ? -longint'(t2) : longint'(t2));
            a = -a;
            if (a > 64'sd549755813887)
            begin
                a = 64'sd549755813887;
                clip = 1'b1;
            end
            if (a < -64'sd549755813888)
            begin
                a = -64'sd549755813888;
                clip = 1'b1;
            end
            if (i == 0)
                res.accel_x = a[39:0];
            else if (i == 1)
                res.accel_y = a[39:0];
            else
                res.accel_z = a[39:0];
        end
        res.saturated = clip;
        return res;
    endfunction

    task automatic enqueue_gravity(item_t it);
        gravity_q = {gravity_q, gravity_of(it)};
    endtask

    assign outstanding = gravity_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            site_q[0] <= '0;
            site_q[1] <= '0;
            site_q[2] <= '0;
            spin_q[0] <= '0;
            spin_q[1] <= 32'h4000_0000;
            spin_q[2] <= '0;
            gm_q <= 49'd398600441800000;
            coeff_q <= 40'd66063000000;
            mismatches <= 0;
            results_seen <= 0;
            gravity_q.delete();
        end
        else
        begin
            if (done)
            begin
                results_seen <= results_seen + 1;
                if (gravity_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result transaction %h", result);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = gravity_q.pop_front();
                    if (want !== result)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: ax %h/%h ay %h/%h az %h/%h r %h/%h sat %b/%b",
                                     want.accel_x, result.accel_x, want.accel_y,
                                     result.accel_y, want.accel_z, result.accel_z,
                                     want.radius, result.radius, want.saturated,
                                     result.saturated);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (start && !busy)
                enqueue_gravity(item);
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[5:3]))
                    REG_SITE_X:       site_q[0] <= pwdata[39:0];
                    REG_SITE_Y:       site_q[1] <= pwdata[39:0];
                    REG_SITE_Z:       site_q[2] <= pwdata[39:0];
                    REG_SPIN_X:       spin_q[0] <= pwdata[31:0];
                    REG_SPIN_Y:       spin_q[1] <= pwdata[31:0];
                    REG_SPIN_Z:       spin_q[2] <= pwdata[31:0];
                    REG_GRAV_PARAM:   gm_q <= pwdata[48:0];
                    REG_OBLATE_COEFF: coeff_q <= pwdata[39:0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

@@ test/tb_j2_gravity_vector.sv @@
module tb_j2_gravity_vector;
    import j2gv_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    item_t               item;
    logic                done;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [AW-1:0]       paddr;
    logic [DW-1:0]       pwdata;
    logic [DW-1:0]       prdata;
    logic                pready;
    int                  mismatches;
    int                  outstanding;
    int                  results_seen;
    int                  idle_cycles;
    int                  items_sent;
    logic [39:0]         site_now [3];

    j2_gravity_vector uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    j2gv_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .mismatches(mismatches), .outstanding(outstanding),
        .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_j2_gravity_vector: FAIL");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AW'(8 * int'(idx));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SITE_X: site_now[0] = value[39:0];
            REG_SITE_Y: site_now[1] = value[39:0];
            REG_SITE_Z: site_now[2] = value[39:0];
            default:    ;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (LAT + 8) @(posedge clk);
    endtask

    task automatic send_position(item_t v);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= v;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic configure(logic [39:0] sx, logic [39:0] sy, logic [39:0] sz,
                             logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                             logic [48:0] gm, logic [39:0] cj);
        write_reg(REG_SITE_X, 64'(sx));
        write_reg(REG_SITE_Y, 64'(sy));
        write_reg(REG_SITE_Z, 64'(sz));
        write_reg(REG_SPIN_X, 64'(wx));
        write_reg(REG_SPIN_Y, 64'(wy));
        write_reg(REG_SPIN_Z, 64'(wz));
        write_reg(REG_GRAV_PARAM, 64'(gm));
        write_reg(REG_OBLATE_COEFF, 64'(cj));
    endtask

    function automatic logic [39:0] any40();
        return {8'($urandom), $urandom};
    endfunction

    function automatic logic [39:0] near40(int bits);
        logic [39:0] v;
        v = any40() >> (40 - bits);
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    function automatic item_t random_position();
        item_t v;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 2)
        begin
            v.pos_x = any40();
            v.pos_y = any40();
            v.pos_z = any40();
        end
        else if (mode == 2)
        begin
            v.pos_x = -site_now[0] + near40(4);
            v.pos_y = -site_now[1] + near40(4);
            v.pos_z = -site_now[2] + near40(4);
        end
        else
        begin
            v.pos_x = near40($urandom_range(20, 36));
            v.pos_y = near40($urandom_range(20, 36));
            v.pos_z = near40($urandom_range(20, 36));
        end
        return v;
    endfunction

    localparam logic [39:0] P_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] P_MIN = 40'h80_0000_0000;
    localparam logic [39:0] EARTH = 40'd1630976000;

    initial
    begin
        item_t v;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        items_sent = 0;
        site_now[0] = '0;
        site_now[1] = '0;
        site_now[2] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_position('{40'd0, 40'd0, 40'd0});
        send_position('{40'd1, 40'd0, 40'd0});
        send_position('{40'd0, 40'd0, 40'd256});
        send_position('{P_MAX, P_MAX, P_MAX});
        send_position('{P_MIN, P_MIN, P_MIN});
        send_position('{P_MAX, P_MIN, 40'd0});
        send_position('{40'd0, EARTH, 40'd0});
        send_position('{EARTH, 40'd0, 40'd0});
        send_position('{40'd0, -EARTH, 40'd0});
        send_position('{40'd1000000, 40'd1000000, 40'd1000000});
        drain();
        configure(P_MAX, P_MAX, P_MAX, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
                  49'h1_FFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
        send_position('{P_MAX, P_MAX, P_MAX});
        send_position('{P_MIN + 40'd1, P_MIN + 40'd1, P_MIN + 40'd1});
        send_position('{40'd0, 40'd0, 40'd0});
        send_position('{40'd0, 40'd0, P_MIN + 40'd2});
        drain();
        configure(P_MIN, 40'd0, 40'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000,
                  49'd0, 40'd0);
        send_position('{P_MIN, 40'd0, 40'd0});
        send_position('{P_MAX, 40'd5, 40'd0});
        send_position('{40'd0, 40'd0, 40'd0});
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: configure('0, '0, EARTH, '0, '0, 32'h4000_0000,
                             49'd398600441800000, 40'd66063000000);
                1: configure(EARTH >> 1, 40'(-(EARTH >> 1)), EARTH, 32'h2D41_3CCD, '0,
                             32'h2D41_3CCD, 49'd398600441800000, 40'hFF_FFFF_FFFF);
                2: configure(any40(), any40(), any40(), $urandom, $urandom, $urandom,
                             {17'($urandom), $urandom}, any40());
                3: configure(P_MAX, P_MIN, '0, 32'hC000_0000, '0, '0,
                             49'h1_FFFF_FFFF_FFFF, 40'd0);
                4: configure(near40(33), near40(33), near40(33), 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 49'd1, 40'd1);
                default: configure('0, EARTH, '0, '0, 32'h4000_0000, '0,
                                   49'd398600441800000, 40'd66063000000);
            endcase
            for (int n = 0; n < 240; n++)
            begin
                v = random_position();
                send_position(v);
            end
            drain();
        end

        $display("Covered %0d position transactions and %0d gravity results", items_sent,
                 results_seen);
        $display("over nine register settings including the extreme register values.");
        if (mismatches == 0 && outstanding == 0)
            $display("tb_j2_gravity_vector: PASS");
        else
            $display("tb_j2_gravity_vector: FAIL");
        $finish;
    end

endmodule
